>>> design/vgma_pkg.sv
// Shared types and constants for the velocity gain / moving average block.
// No dependencies; imported by vgma_gain, vgma_div and the top level.
package vgma_pkg;

	localparam int VEL_W     = 32;
	localparam int GAIN_W    = 16;
	localparam int GAIN_FRAC = 14;
	localparam int SUM_W     = 36;
	localparam int CNT_W     = 5;
	localparam int NUM_CHAN  = 3;
	localparam int CFG_IDX_W = 2;

	// radix-4 divider: two dividend bits per step
	localparam int DIV_STEPS  = SUM_W / 2;
	localparam int DIV_STEP_W = $clog2(DIV_STEPS);

	localparam logic [GAIN_W-1:0] GAIN_ONE = 16'd16384;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_GAIN_X    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_GAIN_Y    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_GAIN_TURN = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_ZERO_BAND = 2'd3;

	// channel codes
	localparam logic [1:0] CH_X    = 2'd0;
	localparam logic [1:0] CH_Y    = 2'd1;
	localparam logic [1:0] CH_TURN = 2'd2;

	typedef struct packed {
		logic signed [VEL_W-1:0] vel_x;
		logic signed [VEL_W-1:0] vel_y;
		logic signed [VEL_W-1:0] vel_turn;
	} vgma_in_t;

	typedef struct packed {
		logic signed [VEL_W-1:0] mean_x;
		logic signed [VEL_W-1:0] mean_y;
		logic signed [VEL_W-1:0] mean_turn;
		logic [CNT_W-1:0]        held_count;
	} vgma_out_t;

	typedef struct packed {
		logic                    start;
		logic signed [SUM_W-1:0] dividend;
		logic [CNT_W-1:0]        divisor;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic             neg;
		logic [VEL_W-1:0] mag;
	} div_rsp_t;

endpackage

>>> design/vgma_gain.sv
// Gain multiplier: signed Q16.16 sample times unsigned Q2.14 gain, registered,
// then floor shift and saturation to 32 bits. Depends on vgma_pkg.
module vgma_gain (
	input  logic                             clk,
	input  logic signed [vgma_pkg::VEL_W-1:0] vel,
	input  logic [vgma_pkg::GAIN_W-1:0]       gain,
	output logic signed [vgma_pkg::VEL_W-1:0] corr
);
	import vgma_pkg::*;

	localparam int PROD_W = VEL_W + GAIN_W + 1;
	localparam int SH_W   = PROD_W - GAIN_FRAC;

	logic signed [GAIN_W:0]   gain_s;
	logic signed [PROD_W-1:0] prod_s1;
	logic signed [SH_W-1:0]   shifted;
	logic                     ovf;

	assign gain_s = $signed({1'b0, gain});

	always_ff @(posedge clk) begin
		prod_s1 <= vel * gain_s;
	end

	// dropping the low bits is an arithmetic shift, i.e. floor
	assign shifted = prod_s1[PROD_W-1:GAIN_FRAC];

	// out of range when the bits above the 32-bit sign are not all copies of it
	assign ovf = (shifted[SH_W-1:VEL_W-1] != {(SH_W-VEL_W+1){shifted[SH_W-1]}});

	always_comb begin
		if (ovf) begin
			corr = shifted[SH_W-1] ? {1'b1, {(VEL_W-1){1'b0}}} : {1'b0, {(VEL_W-1){1'b1}}};
		end else begin
			corr = shifted[VEL_W-1:0];
		end
	end

endmodule

>>> design/vgma_div.sv
// Iterative radix-4 divider: 36-bit signed sum by a 5-bit count, truncating
// toward zero. Returns sign and 32-bit magnitude. Depends on vgma_pkg.
module vgma_div (
	input  logic                clk,
	input  logic                arst_n,
	input  vgma_pkg::div_req_t  req,
	output vgma_pkg::div_rsp_t  rsp
);
	import vgma_pkg::*;

	localparam int REM_W = CNT_W - 1;   // remainder < divisor <= 16
	localparam int TR_W  = CNT_W + 2;

	logic                  busy_q;
	logic                  done_q;
	logic [DIV_STEP_W-1:0] step_q;
	logic [SUM_W-1:0]      work_q;   // dividend shifts out the top, quotient in the bottom
	logic [REM_W-1:0]      rem_q;
	logic [CNT_W-1:0]      d_q;
	logic                  neg_q;

	logic [SUM_W-1:0] dvd_mag;
	logic [TR_W-1:0]  trial, d1, d2, d3, rem_nxt;
	logic [1:0]       digit;

	assign dvd_mag = req.dividend[SUM_W-1] ? (~req.dividend + SUM_W'(1)) : req.dividend;

	assign trial = {1'b0, rem_q, work_q[SUM_W-1 -: 2]};
	assign d1    = TR_W'(d_q);
	assign d2    = TR_W'({d_q, 1'b0});
	assign d3    = d1 + d2;

	always_comb begin
		if (trial >= d3) begin
			digit   = 2'd3;
			rem_nxt = trial - d3;
		end else if (trial >= d2) begin
			digit   = 2'd2;
			rem_nxt = trial - d2;
		end else if (trial >= d1) begin
			digit   = 2'd1;
			rem_nxt = trial - d1;
		end else begin
			digit   = 2'd0;
			rem_nxt = trial;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			// one-cycle pulse after the last step
			done_q <= !req.start && busy_q && (step_q == DIV_STEP_W'(DIV_STEPS - 1));
			if (req.start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				if (step_q == DIV_STEP_W'(DIV_STEPS - 1)) begin
					busy_q <= 1'b0;
				end
				step_q <= step_q + DIV_STEP_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			work_q <= dvd_mag;
			rem_q  <= '0;
			d_q    <= req.divisor;
			neg_q  <= req.dividend[SUM_W-1];
		end else if (busy_q) begin
			work_q <= {work_q[SUM_W-3:0], digit};
			rem_q  <= rem_nxt[REM_W-1:0];
		end
	end

	// |mean| never exceeds 2^31, so the low 32 bits hold the whole magnitude
	assign rsp.done = done_q;
	assign rsp.neg  = neg_q;
	assign rsp.mag  = work_q[VEL_W-1:0];

	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(busy_q))
		else $error("divider done without a running division");

	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		req.start |-> !busy_q)
		else $error("divider restarted while busy");

	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q)
		else $error("divider done held for more than one cycle");

endmodule

>>> design/velocity_gain_moving_average_top.sv
// Velocity gain correction and moving-average filter with warm-up, top level.
// Depends on vgma_pkg, vgma_gain and vgma_div.
//
// Each request carries one body velocity sample (x, y, turn, signed Q16.16).
// The three channels are handled one after another: the gain multiply, the
// running-sum update and a shared radix-4 divider that divides the sum by the
// number of held samples. For each channel in turn the block passes through a
// multiply state, an accumulate state and a divide state, in which the divider
// runs its 18 two-bit steps and then signals done; after the third channel
// the result register is loaded and the block returns to idle, where the
// next request is accepted. in_stall is high while a request is in work. The
// result register frees the input side, so a new request is taken while the
// previous result still waits on out_stall; the done state only holds while
// an earlier result has not yet been taken.
// Sums and fill state clear at reset, not the slots; there is no clearing pass.
module velocity_gain_moving_average_top #(
	parameter int WINDOW = 4
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [vgma_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [vgma_pkg::GAIN_W-1:0]        cfg_data,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  vgma_pkg::vgma_in_t                 in_data,
	output logic                               out_valid,
	input  logic                               out_stall,
	output vgma_pkg::vgma_out_t                out_data
);
	import vgma_pkg::*;

	localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
	localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(WINDOW - 1);
	localparam logic [CNT_W-1:0]  CNT_FULL  = CNT_W'(WINDOW);

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_MUL  = 5'b00010,
		ST_SUM  = 5'b00100,
		ST_DIV  = 5'b01000,
		ST_DONE = 5'b10000
	} state_t;

	state_t state_q;

	logic [GAIN_W-1:0] gain_x_q, gain_y_q, gain_turn_q, zero_band_q;

	logic [1:0]              chan_q;
	logic [SLOT_W-1:0]       slot_q;
	logic                    full_q;
	logic signed [SUM_W-1:0] sum_q [NUM_CHAN];
	logic                    out_valid_q;

	vgma_in_t                in_q;
	logic [CNT_W-1:0]        cnt_q;
	logic signed [VEL_W-1:0] res_q [NUM_CHAN];
	logic signed [VEL_W-1:0] ring_q [WINDOW][NUM_CHAN];
	vgma_out_t               out_q;

	logic signed [VEL_W-1:0] vel_sel;
	logic [GAIN_W-1:0]       gain_sel;
	logic signed [VEL_W-1:0] corr;
	logic signed [SUM_W-1:0] old_ext, corr_ext, sum_new;
	logic [VEL_W-1:0]        mean_mag;
	logic signed [VEL_W-1:0] mean_val;
	div_req_t                div_req;
	div_rsp_t                div_rsp;
	logic                    out_free;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_x_q    <= GAIN_ONE;
			gain_y_q    <= GAIN_ONE;
			gain_turn_q <= GAIN_ONE;
			zero_band_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_GAIN_X:    gain_x_q    <= cfg_data;
				CFG_GAIN_Y:    gain_y_q    <= cfg_data;
				CFG_GAIN_TURN: gain_turn_q <= cfg_data;
				CFG_ZERO_BAND: zero_band_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		case (chan_q)
			CH_X: begin
				vel_sel  = in_q.vel_x;
				gain_sel = gain_x_q;
			end
			CH_Y: begin
				vel_sel  = in_q.vel_y;
				gain_sel = gain_y_q;
			end
			default: begin
				vel_sel  = in_q.vel_turn;
				gain_sel = gain_turn_q;
			end
		endcase
	end

	vgma_gain u_gain (
		.clk  (clk),
		.vel  (vel_sel),
		.gain (gain_sel),
		.corr (corr)
	);

	// drop the oldest sample once the window has filled
	assign old_ext  = full_q ? SUM_W'(ring_q[slot_q][chan_q]) : '0;
	assign corr_ext = SUM_W'(corr);
	assign sum_new  = sum_q[chan_q] - old_ext + corr_ext;

	assign div_req.start    = (state_q == ST_SUM);
	assign div_req.dividend = sum_new;
	assign div_req.divisor  = cnt_q;

	vgma_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// dead band on the magnitude, then restore the sign
	assign mean_mag = div_rsp.mag;
	always_comb begin
		if (mean_mag < VEL_W'(zero_band_q)) begin
			mean_val = '0;
		end else if (div_rsp.neg) begin
			mean_val = ~mean_mag + VEL_W'(1);
		end else begin
			mean_val = mean_mag;
		end
	end

	assign out_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			chan_q      <= CH_X;
			slot_q      <= '0;
			full_q      <= 1'b0;
			out_valid_q <= 1'b0;
			for (int c = 0; c < NUM_CHAN; c++) begin
				sum_q[c] <= '0;
			end
		end else begin
			if (state_q == ST_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						chan_q  <= CH_X;
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					state_q <= ST_SUM;
				end
				ST_SUM: begin
					sum_q[chan_q] <= sum_new;
					state_q       <= ST_DIV;
				end
				ST_DIV: begin
					if (div_rsp.done) begin
						if (chan_q == CH_TURN) begin
							state_q <= ST_DONE;
						end else begin
							chan_q  <= chan_q + 2'd1;
							state_q <= ST_MUL;
						end
					end
				end
				ST_DONE: begin
					if (out_free) begin
						slot_q      <= (slot_q == SLOT_LAST) ? '0 : slot_q + SLOT_W'(1);
						full_q      <= full_q || (slot_q == SLOT_LAST);
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// request payload, results and sample window
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_valid) begin
			in_q  <= in_data;
			cnt_q <= full_q ? CNT_FULL : CNT_W'(slot_q) + CNT_W'(1);
		end
		if (state_q == ST_SUM) begin
			ring_q[slot_q][chan_q] <= corr;
		end
		if (state_q == ST_DIV && div_rsp.done) begin
			res_q[chan_q] <= mean_val;
		end
		if (state_q == ST_DONE && out_free) begin
			out_q.mean_x     <= res_q[CH_X];
			out_q.mean_y     <= res_q[CH_Y];
			out_q.mean_turn  <= res_q[CH_TURN];
			out_q.held_count <= cnt_q;
		end
	end

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	a_out_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_DONE))
		else $error("result appeared outside the done state");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_q.held_count != '0) && (out_q.held_count <= CNT_FULL))
		else $error("held count out of range");

	a_div_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> state_q == ST_DIV)
		else $error("divider finished outside the divide state");

	a_chan_valid: assert property (@(posedge clk) disable iff (!arst_n)
		chan_q != 2'd3)
		else $error("channel counter ran past the last channel");

endmodule

>>> bench/testbench.sv
// Self-checking bench for velocity_gain_moving_average_top: gain correction,
// saturation, warm-up windowed mean and dead band, checked request by request.
// Depends on vgma_pkg and the design sources only.
module testbench;
	import vgma_pkg::*;

	localparam int WINDOW      = 4;
	localparam int CYCLE_LIMIT = 400000;
	localparam int TAIL_CYCLES = 100;
	localparam int MAX_SHOWN   = 10;

	// Tracks gains, band, sample window and sums; predicts one mean per request.
	class mean_tracker;
		logic [GAIN_W-1:0]       gain [NUM_CHAN];
		logic [GAIN_W-1:0]       band;
		logic signed [VEL_W-1:0] ring [WINDOW][NUM_CHAN];
		longint                  sums [NUM_CHAN];
		int                      slot;
		bit                      full;
		vgma_out_t               expected_means [$];
		int                      errors;

		function new();
			foreach (gain[ch])
				gain[ch] = GAIN_ONE;
			band = '0;
			foreach (ring[i, ch])
				ring[i][ch] = '0;
			foreach (sums[ch])
				sums[ch] = 0;
			slot   = 0;
			full   = 1'b0;
			errors = 0;
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [GAIN_W-1:0] val);
			case (idx)
				CFG_GAIN_X:    gain[0] = val;
				CFG_GAIN_Y:    gain[1] = val;
				CFG_GAIN_TURN: gain[2] = val;
				CFG_ZERO_BAND: band = val;
				default: ;
			endcase
		endfunction

		function logic signed [VEL_W-1:0] scale_by_gain(logic signed [VEL_W-1:0] v,
				logic [GAIN_W-1:0] g);
			longint p;
			longint gl;
			p  = v;
			gl = g;
			p  = (p * gl) >>> GAIN_FRAC;
			if (p > 64'sd2147483647)
				p = 64'sd2147483647;
			if (p < -64'sd2147483648)
				p = -64'sd2147483648;
			return p[VEL_W-1:0];
		endfunction

		function longint apply_band(longint m);
			longint mag;
			longint lim;
			mag = (m < 0) ? -m : m;
			lim = band;
			return (mag < lim) ? 64'sd0 : m;
		endfunction

		function void note_sample(vgma_in_t s);
			logic signed [VEL_W-1:0] c [NUM_CHAN];
			longint                  m [NUM_CHAN];
			vgma_out_t               e;
			int                      count;
			c[0] = scale_by_gain(s.vel_x, gain[0]);
			c[1] = scale_by_gain(s.vel_y, gain[1]);
			c[2] = scale_by_gain(s.vel_turn, gain[2]);
			for (int ch = 0; ch < NUM_CHAN; ch++) begin
				if (full)
					sums[ch] -= ring[slot][ch];
				sums[ch] += c[ch];
				ring[slot][ch] = c[ch];
			end
			slot++;
			if (slot >= WINDOW) begin
				slot = 0;
				full = 1'b1;
			end
			count = full ? WINDOW : slot;
			// longint division truncates toward zero
			for (int ch = 0; ch < NUM_CHAN; ch++)
				m[ch] = apply_band(sums[ch] / count);
			e.mean_x     = m[0][VEL_W-1:0];
			e.mean_y     = m[1][VEL_W-1:0];
			e.mean_turn  = m[2][VEL_W-1:0];
			e.held_count = count[CNT_W-1:0];
			expected_means.push_back(e);
		endfunction

		function void flag(string msg);
			errors++;
			if (errors <= MAX_SHOWN)
				$display("%s", msg);
		endfunction

		function void check_mean(vgma_out_t got);
			vgma_out_t e;
			if (expected_means.size() == 0) begin
				flag($sformatf("unexpected result x=%0d y=%0d turn=%0d n=%0d",
					got.mean_x, got.mean_y, got.mean_turn, got.held_count));
				return;
			end
			e = expected_means.pop_front();
			if (got.mean_x !== e.mean_x || got.mean_y !== e.mean_y ||
					got.mean_turn !== e.mean_turn || got.held_count !== e.held_count)
				flag($sformatf({"mean mismatch: exp x=%0d y=%0d turn=%0d n=%0d",
					" got x=%0d y=%0d turn=%0d n=%0d"},
					e.mean_x, e.mean_y, e.mean_turn, e.held_count,
					got.mean_x, got.mean_y, got.mean_turn, got.held_count));
		endfunction

		function int pending();
			return expected_means.size();
		endfunction
	endclass

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = CFG_GAIN_X;
	logic [GAIN_W-1:0]     cfg_data  = '0;
	logic                  in_valid  = 1'b0;
	logic                  in_stall;
	vgma_in_t              in_data   = '0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	vgma_out_t             out_data;

	mean_tracker tracker = new();
	int          cycle_count = 0;
	bit          tx_idle_on  = 1'b1;
	bit          rx_idle_on  = 1'b1;

	velocity_gain_moving_average_top #(.WINDOW(WINDOW)) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			tracker.check_mean(out_data);
	end

	// result side: random hold-off before each result
	initial begin
		int wait_n;
		forever begin
			wait_n = rx_idle_on ? $urandom_range(0, 5) : 0;
			if (wait_n > 0) begin
				out_stall <= 1'b1;
				repeat (wait_n) @(posedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (!out_valid);
		end
	end

	function automatic vgma_in_t sample(logic signed [VEL_W-1:0] x,
			logic signed [VEL_W-1:0] y, logic signed [VEL_W-1:0] t);
		vgma_in_t s;
		s.vel_x    = x;
		s.vel_y    = y;
		s.vel_turn = t;
		return s;
	endfunction

	function automatic logic signed [VEL_W-1:0] rand_vel();
		logic signed [VEL_W-1:0] v;
		case ($urandom_range(0, 7)) inside
			0:       v = 32'sh7fffffff;
			1:       v = 32'sh80000000;
			2, 3: begin
				v = $urandom_range(0, 262143);
				v = v - 131072;
			end
			4: begin
				v = $urandom_range(0, 31);
				v = v - 16;
			end
			default: v = $urandom;
		endcase
		return v;
	endfunction

	function automatic logic [GAIN_W-1:0] rand_gain();
		case ($urandom_range(0, 5))
			0:       return '0;
			1:       return '1;
			2:       return GAIN_ONE;
			default: return GAIN_W'($urandom_range(0, 65535));
		endcase
	endfunction

	function automatic logic [GAIN_W-1:0] rand_band();
		case ($urandom_range(0, 4))
			0:       return '0;
			1:       return '1;
			2:       return GAIN_W'($urandom_range(0, 65535));
			default: return GAIN_W'($urandom_range(0, 2000));
		endcase
	endfunction

	task automatic load_regs(input logic [GAIN_W-1:0] gx, gy, gt, zb);
		logic [CFG_IDX_W-1:0] idx  [4];
		logic [GAIN_W-1:0]    vals [4];
		idx  = '{CFG_GAIN_X, CFG_GAIN_Y, CFG_GAIN_TURN, CFG_ZERO_BAND};
		vals = '{gx, gy, gt, zb};
		for (int i = 0; i < 4; i++) begin
			cfg_we    <= 1'b1;
			cfg_index <= idx[i];
			cfg_data  <= vals[i];
			@(posedge clk);
			tracker.set_reg(idx[i], vals[i]);
		end
		cfg_we <= 1'b0;
	endtask

	// one request; valid stays high across back-to-back requests
	task automatic send_sample(input vgma_in_t s);
		int gap;
		gap = tx_idle_on ? $urandom_range(0, 5) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= s;
		do @(posedge clk); while (in_stall);
		tracker.note_sample(s);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (tracker.pending() != 0)
			@(posedge clk);
	endtask

	initial begin
		vgma_in_t s;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset gains: warm-up counts 1..4, then the window wraps
		send_sample(sample(0, 0, 0));
		send_sample(sample(32'sh7fffffff, 32'sh80000000, -1));
		send_sample(sample(32'sh80000000, 32'sh7fffffff, 1));
		send_sample(sample(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff));
		send_sample(sample(32'sh80000000, 32'sh80000000, 32'sh80000000));
		send_sample(sample(1, -1, 0));
		drain();

		// top gain saturates both ways, zero gain, floor on negative products
		load_regs('1, '1, '0, '0);
		send_sample(sample(32'sh7fffffff, 32'sh80000000, 32'sh7fffffff));
		send_sample(sample(32'sh80000000, 32'sh7fffffff, 32'sh80000000));
		send_sample(sample(32768, -32768, 5));
		send_sample(sample(-1, 1, 32'sh80000000));
		send_sample(sample(-3, 3, -7));
		drain();

		// widest dead band: means at and just under the band edge
		load_regs(GAIN_ONE, 16'd8191, 16'd1, '1);
		repeat (4) send_sample(sample(65535, 131072, 100));
		send_sample(sample(65534, -65536, -65535));
		send_sample(sample(65534, -65536, -65535));
		send_sample(sample(-65535, 65535, 32'sh80000000));
		drain();

		// small band with small values so it trips often
		load_regs(GAIN_ONE, GAIN_ONE, GAIN_ONE, 16'd8);
		send_sample(sample(7, -7, 8));
		send_sample(sample(-8, 9, -9));
		send_sample(sample(32'sh80000000, 0, 0));
		drain();

		for (int phase = 0; phase < 8; phase++) begin
			tx_idle_on = (phase % 3) != 1;
			rx_idle_on = (phase % 4) != 2;
			if (phase == 0)
				load_regs('1, '0, '1, '1);
			else if (phase == 1)
				load_regs('0, '1, GAIN_ONE, '0);
			else
				load_regs(rand_gain(), rand_gain(), rand_gain(), rand_band());
			for (int i = 0; i < 62; i++) begin
				s.vel_x    = rand_vel();
				s.vel_y    = rand_vel();
				s.vel_turn = rand_vel();
				send_sample(s);
			end
			drain();
		end

		repeat (TAIL_CYCLES) @(posedge clk);
		if (tracker.pending() != 0)
			tracker.flag($sformatf("%0d results never arrived", tracker.pending()));
		if (tracker.errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

>>> sim.f
design/vgma_pkg.sv
design/vgma_gain.sv
design/vgma_div.sv
design/velocity_gain_moving_average_top.sv
bench/testbench.sv
